[rtl/core/medt_pkg.sv]
// Shared constants and types for the mesh edge dedup table.
`timescale 1ns / 1ps

package medt_pkg;

    localparam int MAX_EDGES   = 1024;
    localparam int VERTEX_BITS = 24;
    localparam int ADDR_BITS   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CNT_BITS    = $clog2(MAX_EDGES + 1);

    localparam int DIMS_W      = 2;
    localparam int INDEX_W     = 10;
    localparam int COUNT_W     = 11;
    localparam int ID_W        = 24;

    localparam logic [DIMS_W-1:0] DIMS_RESET = 2'd3;

    typedef logic [VERTEX_BITS-1:0] t_vertex;

    typedef struct packed {
        t_vertex first;
        t_vertex second;
    } t_pair;

endpackage

[rtl/core/medt_pair_ram.sv]
// Edge table storage: one write port, one registered read port.
`timescale 1ns / 1ps

module medt_pair_ram (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [medt_pkg::ADDR_BITS-1:0] i_wr_addr,
    input  medt_pkg::t_pair               i_wr_data,
    input  logic                          i_rd_en,
    input  logic [medt_pkg::ADDR_BITS-1:0] i_rd_addr,
    output medt_pkg::t_pair               o_rd_data
);

    medt_pkg::t_pair r_mem [medt_pkg::MAX_EDGES];
    medt_pkg::t_pair r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/mesh_edge_dedup_table.sv]
// Top level of the mesh edge dedup table: pair sequencer, table search and result word.
`timescale 1ns / 1ps

// A cell is taken when start is high and busy is low; busy falls in the cycle that
// carries the cell's last result word on o_strobe. Each vertex pair (1, 3 or 6 per
// cell) is looked up by reading the stored edge table one entry per cycle
// through its single read port, stopping at the first match or at the end of
// the stored entries.
// Result words leave one per pair on o_strobe, each for a single cycle, and the
// receiver cannot stall them. A cell marked last clears the edge count once its
// pairs are done.
module mesh_edge_dedup_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [medt_pkg::DIMS_W-1:0]   i_cfg_wdata,
    input  logic                          start,
    output logic                          busy,
    input  logic [medt_pkg::ID_W-1:0]     i_vertex_a,
    input  logic [medt_pkg::ID_W-1:0]     i_vertex_b,
    input  logic [medt_pkg::ID_W-1:0]     i_vertex_c,
    input  logic [medt_pkg::ID_W-1:0]     i_vertex_d,
    input  logic                          i_last_cell,
    output logic                          o_strobe,
    output logic [medt_pkg::INDEX_W-1:0]  o_edge_index,
    output logic                          o_edge_is_new,
    output logic [medt_pkg::COUNT_W-1:0]  o_edge_count,
    output logic                          o_table_overflow,
    output logic                          o_last_of_cell
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SETUP  = 3'b010,
        S_SEARCH = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [medt_pkg::DIMS_W-1:0]    r_num_dims;
    medt_pkg::t_vertex              r_vtx_a, r_vtx_b, r_vtx_c, r_vtx_d;
    logic                           r_last_cell;
    logic [1:0]                     r_pi, n_pi, r_pj, n_pj;
    medt_pkg::t_vertex              r_p, r_q, w_p, w_q;
    logic [medt_pkg::CNT_BITS-1:0]  r_addr, n_addr;
    logic [medt_pkg::CNT_BITS-1:0]  r_count, n_count;
    logic [medt_pkg::ADDR_BITS-1:0] r_cmp_idx, n_cmp_idx;
    logic                           r_cmp_vld, n_cmp_vld;

    logic                           r_strobe, n_strobe;
    logic [medt_pkg::INDEX_W-1:0]   r_edge_index, n_edge_index;
    logic                           r_edge_is_new, n_edge_is_new;
    logic [medt_pkg::COUNT_W-1:0]   r_edge_count, n_edge_count;
    logic                           r_overflow, n_overflow;
    logic                           r_last_of_cell, n_last_of_cell;

    logic [2:0]                     w_nv;
    logic                           w_last_pair;
    logic                           w_match;
    logic                           w_more;
    logic                           w_full;
    logic                           w_rd_en;
    logic                           w_wr_en;
    medt_pkg::t_pair                w_wr_data;
    medt_pkg::t_pair                w_rd_data;

    medt_pair_ram u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_count[medt_pkg::ADDR_BITS-1:0]),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_addr[medt_pkg::ADDR_BITS-1:0]),
        .o_rd_data (w_rd_data)
    );

    assign w_wr_data.first  = r_p;
    assign w_wr_data.second = r_q;

    always_comb begin
        if (r_num_dims == '0) begin
            w_nv = 3'd2;
        end else begin
            w_nv = {1'b0, r_num_dims} + 3'd1;
        end
    end

    assign w_last_pair = (({1'b0, r_pi} + 3'd2) == w_nv);

    always_comb begin
        unique case (r_pi)
            2'd0: w_p = r_vtx_a;
            2'd1: w_p = r_vtx_b;
            2'd2: w_p = r_vtx_c;
            2'd3: w_p = r_vtx_d;
        endcase
        unique case (r_pj)
            2'd0: w_q = r_vtx_a;
            2'd1: w_q = r_vtx_b;
            2'd2: w_q = r_vtx_c;
            2'd3: w_q = r_vtx_d;
        endcase
    end

    assign w_match = r_cmp_vld &&
        ((w_rd_data.first == r_p && w_rd_data.second == r_q) ||
         (w_rd_data.first == r_q && w_rd_data.second == r_p));
    assign w_more  = (r_addr < r_count);
    assign w_full  = (r_count == medt_pkg::CNT_BITS'(medt_pkg::MAX_EDGES));

    always_comb begin
        n_state        = r_state;
        n_pi           = r_pi;
        n_pj           = r_pj;
        n_addr         = r_addr;
        n_count        = r_count;
        n_cmp_idx      = r_cmp_idx;
        n_cmp_vld      = r_cmp_vld;
        n_strobe       = 1'b0;
        n_edge_index   = r_edge_index;
        n_edge_is_new  = r_edge_is_new;
        n_edge_count   = r_edge_count;
        n_overflow     = r_overflow;
        n_last_of_cell = r_last_of_cell;
        w_rd_en        = 1'b0;
        w_wr_en        = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_pi    = 2'd0;
                    n_pj    = 2'd1;
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_addr    = '0;
                n_cmp_vld = 1'b0;
                n_state   = S_SEARCH;
            end
            S_SEARCH: begin
                if (w_match || !w_more) begin
                    n_strobe       = 1'b1;
                    n_last_of_cell = w_last_pair;
                    n_cmp_vld      = 1'b0;
                    if (w_match) begin
                        n_edge_index  = medt_pkg::INDEX_W'(r_cmp_idx);
                        n_edge_is_new = 1'b0;
                        n_overflow    = 1'b0;
                        n_edge_count  = medt_pkg::COUNT_W'(r_count);
                    end else if (!w_full) begin
                        w_wr_en       = 1'b1;
                        n_count       = r_count + 1'b1;
                        n_edge_index  = medt_pkg::INDEX_W'(r_count);
                        n_edge_is_new = 1'b1;
                        n_overflow    = 1'b0;
                        n_edge_count  = medt_pkg::COUNT_W'(r_count + 1'b1);
                    end else begin
                        n_edge_index  = '0;
                        n_edge_is_new = 1'b0;
                        n_overflow    = 1'b1;
                        n_edge_count  = medt_pkg::COUNT_W'(r_count);
                    end
                    if (w_last_pair) begin
                        if (r_last_cell) begin
                            n_count = '0;
                        end
                        n_state = S_IDLE;
                    end else begin
                        if (({1'b0, r_pj} + 3'd1) < w_nv) begin
                            n_pj = r_pj + 2'd1;
                        end else begin
                            n_pi = r_pi + 2'd1;
                            n_pj = r_pi + 2'd2;
                        end
                        n_state = S_SETUP;
                    end
                end else begin
                    w_rd_en   = 1'b1;
                    n_addr    = r_addr + 1'b1;
                    n_cmp_idx = r_addr[medt_pkg::ADDR_BITS-1:0];
                    n_cmp_vld = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_num_dims <= medt_pkg::DIMS_RESET;
            r_pi       <= '0;
            r_pj       <= '0;
            r_addr     <= '0;
            r_count    <= '0;
            r_cmp_vld  <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pi      <= n_pi;
            r_pj      <= n_pj;
            r_addr    <= n_addr;
            r_count   <= n_count;
            r_cmp_vld <= n_cmp_vld;
            r_strobe  <= n_strobe;
            if (i_cfg_we) begin
                r_num_dims <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_vtx_a     <= medt_pkg::VERTEX_BITS'(i_vertex_a);
            r_vtx_b     <= medt_pkg::VERTEX_BITS'(i_vertex_b);
            r_vtx_c     <= medt_pkg::VERTEX_BITS'(i_vertex_c);
            r_vtx_d     <= medt_pkg::VERTEX_BITS'(i_vertex_d);
            r_last_cell <= i_last_cell;
        end
        if (r_state == S_SETUP) begin
            r_p <= w_p;
            r_q <= w_q;
        end
        r_cmp_idx      <= n_cmp_idx;
        r_edge_index   <= n_edge_index;
        r_edge_is_new  <= n_edge_is_new;
        r_edge_count   <= n_edge_count;
        r_overflow     <= n_overflow;
        r_last_of_cell <= n_last_of_cell;
    end

    assign busy             = (r_state != S_IDLE);
    assign o_strobe         = r_strobe;
    assign o_edge_index     = r_edge_index;
    assign o_edge_is_new    = r_edge_is_new;
    assign o_edge_count     = r_edge_count;
    assign o_table_overflow = r_overflow;
    assign o_last_of_cell   = r_last_of_cell;

endmodule

[bench/mesh_edge_dedup_table_tb.sv]
// Self-checking testbench for the mesh edge dedup table: directed cells, table fill and random meshes.
`timescale 1ns / 1ps

module mesh_edge_dedup_table_tb;
    import medt_pkg::*;

    localparam int QUIET_LIMIT = 10000;
    localparam int TAIL_CYCLES = 1100;
    localparam int FILL_CELLS  = MAX_EDGES / 6 + 1;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               is_new;
        logic [COUNT_W-1:0] count;
        logic               overflow;
        logic               closes_cell;
    } t_edge_word;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [DIMS_W-1:0]   i_cfg_wdata = '0;
    logic                start = 1'b0;
    logic                busy;
    logic [ID_W-1:0]     i_vertex_a = '0;
    logic [ID_W-1:0]     i_vertex_b = '0;
    logic [ID_W-1:0]     i_vertex_c = '0;
    logic [ID_W-1:0]     i_vertex_d = '0;
    logic                i_last_cell = 1'b0;
    logic                o_strobe;
    logic [INDEX_W-1:0]  o_edge_index;
    logic                o_edge_is_new;
    logic [COUNT_W-1:0]  o_edge_count;
    logic                o_table_overflow;
    logic                o_last_of_cell;

    t_vertex             edge_first_id [MAX_EDGES];
    t_vertex             edge_second_id [MAX_EDGES];
    int                  edge_total = 0;
    logic [DIMS_W-1:0]   dims_cfg = DIMS_RESET;
    t_edge_word          expected_edges[$];
    int                  fail_count = 0;
    int                  idle_cycles = 0;

    mesh_edge_dedup_table dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .start            (start),
        .busy             (busy),
        .i_vertex_a       (i_vertex_a),
        .i_vertex_b       (i_vertex_b),
        .i_vertex_c       (i_vertex_c),
        .i_vertex_d       (i_vertex_d),
        .i_last_cell      (i_last_cell),
        .o_strobe         (o_strobe),
        .o_edge_index     (o_edge_index),
        .o_edge_is_new    (o_edge_is_new),
        .o_edge_count     (o_edge_count),
        .o_table_overflow (o_table_overflow),
        .o_last_of_cell   (o_last_of_cell)
    );

    always #4 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        fail_count++;
    endtask

    function automatic void number_cell_edges(input t_vertex a, b, c, d, input logic closes);
        t_vertex    ids [4];
        int         corners;
        int         hit;
        t_edge_word w;
        ids[0] = a;
        ids[1] = b;
        ids[2] = c;
        ids[3] = d;
        corners = (dims_cfg == 0) ? 2 : int'(dims_cfg) + 1;
        for (int i = 0; i + 1 < corners; i++) begin
            for (int j = i + 1; j < corners; j++) begin
                hit = -1;
                for (int e = 0; e < edge_total; e++) begin
                    if ((edge_first_id[e] == ids[i] && edge_second_id[e] == ids[j]) ||
                        (edge_first_id[e] == ids[j] && edge_second_id[e] == ids[i])) begin
                        hit = e;
                        break;
                    end
                end
                w = '0;
                w.closes_cell = (i + 2 == corners);
                if (hit >= 0) begin
                    w.index = hit[INDEX_W-1:0];
                end else if (edge_total < MAX_EDGES) begin
                    edge_first_id[edge_total]  = ids[i];
                    edge_second_id[edge_total] = ids[j];
                    w.index  = edge_total[INDEX_W-1:0];
                    w.is_new = 1'b1;
                    edge_total++;
                end else begin
                    w.overflow = 1'b1;
                end
                w.count = edge_total[COUNT_W-1:0];
                expected_edges.push_back(w);
            end
        end
        if (closes)
            edge_total = 0;
    endfunction

    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 65)
            return 0;
        if (roll < 93)
            return $urandom_range(4, 1);
        return $urandom_range(300, 20);
    endfunction

    always @(posedge i_clk) begin
        t_edge_word w;
        if (i_rst_n && o_strobe) begin
            if (expected_edges.size() == 0) begin
                report_mismatch($sformatf("unexpected word index %0d", o_edge_index));
            end else begin
                w = expected_edges.pop_front();
                if (o_edge_index !== w.index)
                    report_mismatch($sformatf("edge_index %0d, want %0d",
                                              o_edge_index, w.index));
                if (o_edge_is_new !== w.is_new)
                    report_mismatch($sformatf("edge_is_new %0b, want %0b",
                                              o_edge_is_new, w.is_new));
                if (o_edge_count !== w.count)
                    report_mismatch($sformatf("edge_count %0d, want %0d",
                                              o_edge_count, w.count));
                if (o_table_overflow !== w.overflow)
                    report_mismatch($sformatf("table_overflow %0b, want %0b",
                                              o_table_overflow, w.overflow));
                if (o_last_of_cell !== w.closes_cell)
                    report_mismatch($sformatf("last_of_cell %0b, want %0b",
                                              o_last_of_cell, w.closes_cell));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_cell(input t_vertex a, b, c, d, input logic closes);
        int gap;
        gap = idle_gap();
        @(posedge i_clk);
        repeat (gap) @(posedge i_clk);
        start       <= 1'b1;
        i_vertex_a  <= a;
        i_vertex_b  <= b;
        i_vertex_c  <= c;
        i_vertex_d  <= d;
        i_last_cell <= closes;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        number_cell_edges(a, b, c, d, closes);
        start <= 1'b0;
    endtask

    task automatic wait_quiet();
        @(posedge i_clk);
        while (expected_edges.size() != 0 || busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_dims(input logic [DIMS_W-1:0] value);
        wait_quiet();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        dims_cfg = value;
    endtask

    task automatic test_directed_cells();
        // reset value of num_dims: four-vertex cells
        send_cell(24'h000000, 24'hFFFFFF, 24'hAAAAAA, 24'h555555, 1'b0);
        send_cell(24'h555555, 24'hAAAAAA, 24'hFFFFFF, 24'h000000, 1'b0);
        send_cell(24'h000005, 24'h000005, 24'h000005, 24'h000005, 1'b0);
        send_cell(24'h000000, 24'hFFFFFF, 24'hAAAAAA, 24'h123456, 1'b0);
        send_cell(24'h123456, 24'h000005, 24'hFFFFFF, 24'hFEDCBA, 1'b1);
        send_cell(24'h000000, 24'hFFFFFF, 24'hAAAAAA, 24'h555555, 1'b0);
        set_dims(2'd0);
        send_cell(24'hFFFFFF, 24'h000000, 24'h0F0F0F, 24'hF0F0F0, 1'b0);
        send_cell(24'h000000, 24'hFFFFFF, 24'h111111, 24'h222222, 1'b0);
        send_cell(24'h000077, 24'h000077, 24'h333333, 24'h444444, 1'b0);
        set_dims(2'd1);
        send_cell(24'hAAAAAA, 24'h000000, 24'h010101, 24'h020202, 1'b0);
        send_cell(24'h800000, 24'h000001, 24'h000000, 24'h000000, 1'b0);
        set_dims(2'd2);
        send_cell(24'h000000, 24'hAAAAAA, 24'h555555, 24'hC3C3C3, 1'b0);
        send_cell(24'h555555, 24'h800000, 24'h000001, 24'h3C3C3C, 1'b0);
        send_cell(24'h000009, 24'h00000A, 24'h000009, 24'h000000, 1'b1);
        send_cell(24'h000000, 24'hAAAAAA, 24'h555555, 24'h000000, 1'b1);
        set_dims(2'd3);
    endtask

    task automatic test_table_overflow();
        t_vertex base;
        for (int k = 0; k < FILL_CELLS; k++) begin
            base = t_vertex'(24'h100000 + 4 * k);
            send_cell(base, t_vertex'(base + 1), t_vertex'(base + 2),
                      t_vertex'(base + 3), 1'b0);
        end
        // table full: hits still resolve, misses overflow
        send_cell(24'h100003, 24'h100002, 24'h100001, 24'h100000, 1'b0);
        send_cell(24'hABCDEF, 24'h100000, 24'h100001, 24'hFEDCBA, 1'b0);
        send_cell(24'h00F00F, 24'h0FF0FF, 24'hF00F00, 24'hFF0FF0, 1'b1);
        send_cell(24'h00F00F, 24'h0FF0FF, 24'hF00F00, 24'hFF0FF0, 1'b1);
    endtask

    task automatic test_random_mesh();
        logic [DIMS_W-1:0] phase_dims [5];
        t_vertex           pool [10];
        t_vertex           ids [4];
        phase_dims[0] = 2'd3;
        phase_dims[1] = 2'd1;
        phase_dims[2] = 2'd0;
        phase_dims[3] = 2'd2;
        phase_dims[4] = 2'd3;
        foreach (phase_dims[p]) begin
            set_dims(phase_dims[p]);
            foreach (pool[n])
                pool[n] = t_vertex'($urandom());
            for (int k = 0; k < 20; k++) begin
                foreach (ids[n]) begin
                    if ($urandom_range(99) < 85)
                        ids[n] = pool[$urandom_range(9)];
                    else
                        ids[n] = t_vertex'($urandom());
                end
                send_cell(ids[0], ids[1], ids[2], ids[3], $urandom_range(7) == 0);
                if ($urandom_range(11) == 0)
                    wait_quiet();
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cells();
        test_table_overflow();
        test_random_mesh();
        while (expected_edges.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_edges.size() != 0)
            report_mismatch($sformatf("%0d words never arrived", expected_edges.size()));
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[mesh_edge_dedup_table.f]
rtl/core/medt_pkg.sv
rtl/core/medt_pair_ram.sv
rtl/core/mesh_edge_dedup_table.sv
bench/mesh_edge_dedup_table_tb.sv
